### sv/upd_pkg.sv
// Shared types, constants and a helper function for the URL percent decoder.
package upd_pkg;

  // Width of the decoded byte counter.
  localparam int CountBits = 16;
  localparam int LimitBits = 16;
  localparam int LenBits   = 16;
  localparam int CmpBits   = (CountBits > LimitBits) ? CountBits : LimitBits;

  localparam logic [LimitBits-1:0] LimitReset = '1;

  // Character codes.
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] HexLetterBase = 8'd10;

  // One result word.
  typedef struct packed {
    logic                is_end;
    logic [7:0]          out_byte;
    logic [LenBits-1:0]  length;
    logic                status;
  } result_t;

  // Results produced by one accepted input word, oldest first.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  // Hex digit decode: bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
      return {1'b0, d[3:0]};
    end else if (c >= CharLowA && c <= CharLowF) begin
      d = c - CharLowA + HexLetterBase;
      return {1'b0, d[3:0]};
    end else if (c >= CharUpA && c <= CharUpF) begin
      d = c - CharUpA + HexLetterBase;
      return {1'b0, d[3:0]};
    end
    return 5'b10000;
  endfunction

endpackage

### sv/upd_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;
  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface upd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_end;
  logic [7:0]                   out_byte;
  logic [upd_pkg::LenBits-1:0]  length;
  logic                         status;
  modport source (output valid, output is_end, output out_byte, output length,
                  output status, input ready);
  modport sink   (input valid, input is_end, input out_byte, input length,
                  input status, output ready);
endinterface

interface upd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [upd_pkg::LimitBits-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/url_percent_decoder.sv
// Each result word is registered into the result queue when its source word is accepted.
// Throughput: one source word per cycle while the four-entry result queue has two
//   free places; the last word of a stream with a data byte yields two results,
//   which the queue drains at one word per cycle while the sink is ready.
// Reset: synchronous rst clears decode state and the queue; out_limit returns to 65535.
// Top level of the URL percent decoder.
module url_percent_decoder (
  input  logic        clk,
  input  logic        rst,
  upd_in_if.sink      src,
  upd_out_if.source   dst,
  upd_cfg_if.sink     cfg
);

  logic [upd_pkg::LimitBits-1:0]  out_limit;
  logic                           accept;
  logic                           room;
  upd_pkg::push_t                 push;

  assign src.ready = room;
  assign accept    = src.valid && room;
  assign cfg.ready = 1'b1;

  // Hold the output limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= upd_pkg::LimitReset;
    end else if (cfg.valid) begin
      out_limit <= cfg.data;
    end
  end

  upd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (src.in_byte),
    .last      (src.last),
    .out_limit (out_limit),
    .push      (push)
  );

  upd_out_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .dst  (dst)
  );

endmodule

### sv/upd_core.sv
// Decode state machine: turns one source word into up to two result words.
module upd_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [7:0]                      in_byte,
  input  logic                            last,
  input  logic [upd_pkg::LimitBits-1:0]   out_limit,
  output upd_pkg::push_t                  push
);

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_PCT,
    PH_HEX1,
    PH_STOP
  } phase_t;

  phase_t                          phase, phase_next;
  logic [3:0]                      high_nibble, high_nibble_next;
  logic [upd_pkg::CountBits-1:0]   out_count, out_count_next;
  logic                            error_flag, error_flag_next;

  logic                            emit;
  logic [7:0]                      dec_byte;
  logic [4:0]                      hex;
  logic                            at_limit;
  logic [upd_pkg::CountBits-1:0]   count_new;
  logic [upd_pkg::LenBits-1:0]     len_new;
  upd_pkg::result_t                data_res, end_res;

  assign hex      = upd_pkg::hex_value(in_byte);
  assign at_limit = (upd_pkg::CmpBits'(out_count) >= upd_pkg::CmpBits'(out_limit))
                    || (out_count == '1);

  // Decode one byte against the current phase.
  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    error_flag_next  = error_flag;
    emit             = 1'b0;
    dec_byte         = 8'h00;
    case (phase)
      PH_NORMAL: begin
        if (at_limit || in_byte == upd_pkg::CharNul) begin
          phase_next = PH_STOP;
        end else if (in_byte == upd_pkg::CharPlus) begin
          emit     = 1'b1;
          dec_byte = upd_pkg::CharSpace;
        end else if (in_byte == upd_pkg::CharPct) begin
          if (last) begin
            error_flag_next = 1'b1;
            phase_next      = PH_STOP;
          end else begin
            phase_next = PH_PCT;
          end
        end else begin
          emit     = 1'b1;
          dec_byte = in_byte;
        end
      end
      PH_PCT: begin
        if (in_byte == upd_pkg::CharPct) begin
          emit       = 1'b1;
          dec_byte   = upd_pkg::CharPct;
          phase_next = PH_NORMAL;
        end else if (hex[4] || last) begin
          error_flag_next = 1'b1;
          phase_next      = PH_STOP;
        end else begin
          high_nibble_next = hex[3:0];
          phase_next       = PH_HEX1;
        end
      end
      PH_HEX1: begin
        if (hex[4]) begin
          error_flag_next = 1'b1;
          phase_next      = PH_STOP;
        end else begin
          emit       = 1'b1;
          dec_byte   = {high_nibble, hex[3:0]};
          phase_next = PH_NORMAL;
        end
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  // Count and build the result words.
  always_comb begin
    count_new = emit ? out_count + 1'b1 : out_count;
    len_new   = upd_pkg::LenBits'(upd_pkg::CmpBits'(count_new));

    data_res.is_end   = 1'b0;
    data_res.out_byte = dec_byte;
    data_res.length   = len_new;
    data_res.status   = 1'b0;

    end_res.is_end    = 1'b1;
    end_res.out_byte  = 8'h00;
    end_res.length    = len_new;
    end_res.status    = error_flag_next;

    push.push0 = accept && (emit || last);
    push.push1 = accept && emit && last;
    push.res0  = emit ? data_res : end_res;
    push.res1  = end_res;

    out_count_next = count_new;
    // Clear for the next stream after the end record.
    if (last) begin
      out_count_next = '0;
    end
  end

  // Hold state; advance on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      high_nibble <= 4'h0;
      out_count   <= '0;
      error_flag  <= 1'b0;
    end else if (accept) begin
      out_count <= out_count_next;
      if (last) begin
        phase       <= PH_NORMAL;
        high_nibble <= 4'h0;
        error_flag  <= 1'b0;
      end else begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        error_flag  <= error_flag_next;
      end
    end
  end

endmodule

### sv/upd_out_fifo.sv
// Four-entry result queue: takes up to two words per cycle, gives one while the sink is ready.
module upd_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  upd_pkg::push_t    push,
  output logic              room,
  upd_out_if.source         dst
);

  upd_pkg::result_t   mem [4];
  logic [1:0]         wr_ptr, rd_ptr;
  logic [2:0]         count, count_next;
  logic               pop;
  logic [1:0]         n_push;

  assign pop    = dst.valid && dst.ready;
  assign n_push = {1'b0, push.push0} + {1'b0, push.push1};
  // Leave space for two words whatever the sink does.
  assign room   = (count <= 3'd2);

  assign dst.valid    = (count != 3'd0);
  assign dst.is_end   = mem[rd_ptr].is_end;
  assign dst.out_byte = mem[rd_ptr].out_byte;
  assign dst.length   = mem[rd_ptr].length;
  assign dst.status   = mem[rd_ptr].status;

  always_comb begin
    count_next = count + {1'b0, n_push} - {2'b00, pop};
  end

  // Store pushed words.
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr + 2'd1] <= push.res1;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

endmodule
